FILE: rtl/core/b64se_pkg.sv
// Package for the base64 stream encoder: word types, the group descriptor
// passed from the front end to the back end, queue sizing and the alphabet map.
// No dependencies.
`default_nettype none

package b64se_pkg;

    localparam int GQ_DEPTH = 2;
    localparam int GQ_AW    = (GQ_DEPTH > 1) ? $clog2(GQ_DEPTH) : 1;
    localparam int GQ_CW    = $clog2(GQ_DEPTH + 1);

    localparam logic [7:0] PAD_CHAR = 8'h3d;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_final;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
        logic       stream_end;
    } out_word_t;

    // One group of three bytes (padded with zeros) and how many of its four
    // characters come from the alphabet; the rest are pads.
    typedef struct packed {
        logic [7:0] g0;
        logic [7:0] g1;
        logic [7:0] g2;
        logic [2:0] nchars;
        logic       fin;
    } group_t;

    typedef struct packed {
        logic full;
        logic empty;
    } gq_stat_t;

    function automatic logic [7:0] sextet_to_char(input logic [5:0] s);
        logic [7:0] s8;
        logic [7:0] ch;
        s8 = {2'b00, s};
        if (s8 < 8'd26) begin
            ch = s8 + 8'd65;
        end
        else if (s8 < 8'd52) begin
            ch = s8 + 8'd71;
        end
        else if (s8 < 8'd62) begin
            ch = s8 - 8'd4;
        end
        else if (s8 == 8'd62) begin
            ch = 8'h2b;
        end
        else begin
            ch = 8'h2f;
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/b64se_front.sv
// Front end of the base64 stream encoder: accepts byte words, gathers
// groups of up to three bytes and pushes finished groups into the queue.
// Depends on b64se_pkg.
`default_nettype none

module b64se_front
    import b64se_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_word_t item,
    input  wire gq_stat_t gq_stat,
    output logic          gq_push,
    output group_t        gq_data
);

    logic [7:0] held_bytes_reg [2];
    logic [7:0] held_bytes_next [2];
    logic [1:0] held_count_reg;
    logic [1:0] held_count_next;
    logic [1:0] n;
    logic       accept;

    assign full   = gq_stat.full;
    assign accept = push && !full;
    assign n      = (held_count_reg >= 2'd2) ? 2'd2 : held_count_reg;

    always_comb
    begin
        held_bytes_next[0] = held_bytes_reg[0];
        held_bytes_next[1] = held_bytes_reg[1];
        held_count_next    = held_count_reg;
        gq_push            = 1'b0;
        gq_data.g0         = held_bytes_reg[0];
        gq_data.g1         = held_bytes_reg[1];
        gq_data.g2         = item.data_byte;
        gq_data.nchars     = 3'd4;
        gq_data.fin        = item.is_final;
        if (n == 2'd0) begin
            gq_data.g0 = item.data_byte;
            gq_data.g1 = 8'h00;
            gq_data.g2 = 8'h00;
            gq_data.nchars = 3'd2;
        end
        else if (n == 2'd1) begin
            gq_data.g1 = item.data_byte;
            gq_data.g2 = 8'h00;
            gq_data.nchars = 3'd3;
        end
        if (accept) begin
            if (n != 2'd2) begin
                held_bytes_next[n[0]] = item.data_byte;
            end
            if (n == 2'd2 || item.is_final) begin
                gq_push         = 1'b1;
                held_count_next = 2'd0;
            end
            else begin
                held_count_next = n + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_bytes_reg[0] <= 8'h00;
            held_bytes_reg[1] <= 8'h00;
            held_count_reg    <= 2'd0;
        end
        else begin
            held_bytes_reg[0] <= held_bytes_next[0];
            held_bytes_reg[1] <= held_bytes_next[1];
            held_count_reg    <= held_count_next;
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg <= 2'd2)
        else $error("held count out of range");
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.is_final) |=> (held_count_reg == 2'd0))
        else $error("final byte did not clear held count");
    a_third_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && held_count_reg == 2'd2) |-> gq_push)
        else $error("third byte of a group did not push a group");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/b64se_group_queue.sv
// Short group queue between the front end and the back end of the encoder.
// Depends on b64se_pkg.
`default_nettype none

module b64se_group_queue
    import b64se_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   wr_en,
    input  wire group_t wr_data,
    input  wire logic   rd_en,
    output group_t      rd_data,
    output gq_stat_t    stat
);

    group_t             mem_reg [GQ_DEPTH];
    logic [GQ_AW-1:0]   wr_ptr_reg;
    logic [GQ_AW-1:0]   wr_ptr_next;
    logic [GQ_AW-1:0]   rd_ptr_reg;
    logic [GQ_AW-1:0]   rd_ptr_next;
    logic [GQ_CW-1:0]   count_reg;
    logic [GQ_CW-1:0]   count_next;
    logic               do_wr;
    logic               do_rd;

    assign stat.full  = (count_reg == GQ_CW'(GQ_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;
    assign rd_data    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == GQ_AW'(GQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == GQ_AW'(GQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !stat.full)
        else $error("group queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !stat.empty)
        else $error("group queue read while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= GQ_CW'(GQ_DEPTH))
        else $error("group queue count out of range");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/b64se_back.sv
// Back end of the encoder: turns the group at the head of the queue into four
// character words, one per cycle while the result side pops them, through an
// output register. Depends on b64se_pkg.
`default_nettype none

module b64se_back
    import b64se_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire gq_stat_t gq_stat,
    input  wire group_t   gq_data,
    output logic          gq_pop,
    output logic          empty,
    input  wire logic     pop,
    output out_word_t     result
);

    logic [1:0] k_reg;
    logic [1:0] k_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_word_t  out_reg;
    out_word_t  out_next;
    logic       load;
    logic [5:0] sextet;

    assign empty  = !out_valid_reg;
    assign result = out_reg;
    // The output register refills in the same cycle that its word is taken, if a group is queued.
    assign load   = !gq_stat.empty && (!out_valid_reg || pop);
    assign gq_pop = load && (k_reg == 2'd3);

    always_comb
    begin
        case (k_reg)
            2'd0:    sextet = gq_data.g0[7:2];
            2'd1:    sextet = {gq_data.g0[1:0], gq_data.g1[7:4]};
            2'd2:    sextet = {gq_data.g1[3:0], gq_data.g2[7:6]};
            default: sextet = gq_data.g2[5:0];
        endcase
    end

    always_comb
    begin
        k_next         = k_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        if (load) begin
            k_next         = k_reg + 2'd1;
            out_valid_next = 1'b1;
            out_next.out_char = ({1'b0, k_reg} < gq_data.nchars) ?
                                sextet_to_char(sextet) : PAD_CHAR;
            out_next.run_last   = (k_reg == 2'd3);
            out_next.stream_end = (k_reg == 2'd3) && gq_data.fin;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            k_reg         <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else begin
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.stream_end) |-> out_reg.run_last)
        else $error("stream end flagged on a word that is not the last of its group");
    a_pop_after_four: assert property (@(posedge clk) disable iff (!rst_n)
        gq_pop |=> (k_reg == 2'd0))
        else $error("character index not reset after a group");
    a_last_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        gq_pop |=> (out_valid_reg && out_reg.run_last))
        else $error("group left the queue without its last word");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/base64_stream_encoder_unit.sv
// Base64 stream encoder (standard alphabet, '=' padding). Each input word
// carries one byte and a flag for the last byte of the stream. Every third
// byte, or a final byte, releases a group of four character words, handed
// out one per cycle while the result side pops them, through the single
// output register of the back end. A group's first word passes through the
// group queue and then that output register before it reaches the result
// ports.
// A two-entry group queue lets the byte side run ahead of the result side.
// No clearing pass after reset. Depends on b64se_pkg and the modules below.
`default_nettype none

module base64_stream_encoder_unit
    import b64se_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_word_t item,
    output logic          empty,
    input  wire logic     pop,
    output out_word_t     result
);

    gq_stat_t gq_stat;
    logic     gq_push;
    logic     gq_pop;
    group_t   gq_wr_data;
    group_t   gq_rd_data;

    b64se_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .gq_stat (gq_stat),
        .gq_push (gq_push),
        .gq_data (gq_wr_data)
    );

    b64se_group_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (gq_push),
        .wr_data (gq_wr_data),
        .rd_en   (gq_pop),
        .rd_data (gq_rd_data),
        .stat    (gq_stat)
    );

    b64se_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .gq_stat (gq_stat),
        .gq_data (gq_rd_data),
        .gq_pop  (gq_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Testbench for base64_stream_encoder_unit: directed and random byte streams with bursty input and
// a stalling result side, checked by a scoreboard that predicts each character word.
// Depends on b64se_pkg and the encoder RTL.

module tb_top;
    import b64se_pkg::*;

    localparam int IDLE_LIMIT    = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_BYTES  = 500;
    localparam int DRAIN_CYCLES  = 16;

    localparam logic [8*64-1:0] B64_ALPHABET =
        {"ABCDEFGHIJKLMNOPQRSTUVWXYZ", "abcdefghijklmnopqrstuvwxyz", "0123456789+/"};

    typedef enum int {POP_ALWAYS, POP_RANDOM, POP_SPARSE, POP_PATTERN} pop_style_t;

    class b64_scoreboard;
        out_word_t  expected_chars[$];
        logic [7:0] held_bytes[2];
        int         held_count;
        int         mismatches;

        function new();
            held_bytes[0] = 8'h00;
            held_bytes[1] = 8'h00;
            held_count    = 0;
            mismatches    = 0;
        endfunction

        function logic [7:0] sextet_char(logic [5:0] s);
            return B64_ALPHABET[8*(63 - int'(s)) +: 8];
        endfunction

        // Called for every accepted input word; queues the four character words
        // that the byte releases, if any.
        function void note_byte(in_word_t w);
            logic [7:0] g0;
            logic [7:0] g1;
            logic [7:0] g2;
            logic [5:0] sx[4];
            int         n;
            int         nchars;
            out_word_t  ch;
            n = (held_count > 2) ? 2 : held_count;
            if (n < 2)
            begin
                held_bytes[n] = w.data_byte;
                n++;
                if (!w.is_final)
                begin
                    held_count = n;
                    return;
                end
                g0     = held_bytes[0];
                g1     = (n == 2) ? held_bytes[1] : 8'h00;
                g2     = 8'h00;
                nchars = n + 1;
            end
            else
            begin
                g0     = held_bytes[0];
                g1     = held_bytes[1];
                g2     = w.data_byte;
                nchars = 4;
            end
            sx[0] = g0[7:2];
            sx[1] = {g0[1:0], g1[7:4]};
            sx[2] = {g1[3:0], g2[7:6]};
            sx[3] = g2[5:0];
            for (int k = 0; k < 4; k++)
            begin
                ch.out_char   = (k < nchars) ? sextet_char(sx[k]) : PAD_CHAR;
                ch.run_last   = (k == 3);
                ch.stream_end = w.is_final && (k == 3);
                expected_chars.push_back(ch);
            end
            held_count = 0;
        endfunction

        function void check_char(out_word_t got);
            out_word_t exp_w;
            if (expected_chars.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: char=%h run_last=%b stream_end=%b",
                             got.out_char, got.run_last, got.stream_end);
                return;
            end
            exp_w = expected_chars.pop_front();
            if (got.out_char !== exp_w.out_char || got.run_last !== exp_w.run_last ||
                got.stream_end !== exp_w.stream_end)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected char=%h run_last=%b stream_end=%b, %s%h %b %b",
                             exp_w.out_char, exp_w.run_last, exp_w.stream_end,
                             "got ", got.out_char, got.run_last, got.stream_end);
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    in_word_t  item;
    logic      empty;
    logic      pop;
    out_word_t result;

    b64_scoreboard sb;
    int            bytes_sent;
    int            burst_left;
    int            chars_seen;

    base64_stream_encoder_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Sends one byte; between bursts the sender drops push for a random gap.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        in_word_t w;
        int       gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 20);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        w.data_byte = b;
        w.is_final  = fin;
        push <= 1'b1;
        item <= w;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_byte(w);
        bytes_sent++;
    endtask

    task automatic send_stream(input logic [7:0] bytes[$]);
        for (int i = 0; i < bytes.size(); i++)
            send_byte(bytes[i], i == bytes.size() - 1);
    endtask

    // Result side: checks every accepted word and stalls on its own pattern,
    // with one long hold-off so that the encoder backs up into its input.
    initial
    begin
        pop_style_t style;
        logic [7:0] pat;
        int         cyc;
        int         hold_left;
        bit         held_once;
        style     = POP_ALWAYS;
        pat       = 8'b1011_0110;
        cyc       = 0;
        hold_left = 0;
        held_once = 0;
        pop       = 1'b0;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                sb.check_char(result);
                chars_seen++;
            end
            cyc++;
            if (cyc % 64 == 0)
            begin
                style = pop_style_t'($urandom_range(0, 3));
                pat   = 8'($urandom_range(1, 255));
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (!held_once && chars_seen >= 200)
            begin
                held_once = 1;
                hold_left = HOLD_CYCLES;
                pop <= 1'b0;
            end
            else
            begin
                case (style)
                    POP_ALWAYS:  pop <= 1'b1;
                    POP_RANDOM:  pop <= 1'($urandom_range(0, 1));
                    POP_SPARSE:  pop <= ($urandom_range(0, 3) == 0);
                    default:     pop <= pat[cyc % 8];
                endcase
            end
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        logic [7:0] dq[$];
        int         len;
        logic [7:0] b;
        sb         = new();
        bytes_sent = 0;
        burst_left = 0;
        chars_seen = 0;
        rst_n      = 1'b0;
        push       = 1'b0;
        item       = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-byte streams, a two-byte stream, groups that end exactly on the final byte
        // (including the bytes that map to '+' and '/') and four- and five-byte streams ending mid-group.
        dq = {8'h00};                      send_stream(dq);
        dq = {8'hff};                      send_stream(dq);
        dq = {8'hff, 8'hff};               send_stream(dq);
        dq = {8'hff, 8'hff, 8'hff};        send_stream(dq);
        dq = {8'h00, 8'h00, 8'h00};        send_stream(dq);
        dq = {8'hfb, 8'hef, 8'hbe};        send_stream(dq);
        dq = {8'h4d, 8'h61, 8'h6e, 8'h4d}; send_stream(dq);
        dq = {8'h80, 8'h01, 8'h7f, 8'hfe, 8'h55};
        send_stream(dq);

        while (bytes_sent < RANDOM_BYTES)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
            dq.delete();
            for (int i = 0; i < len; i++)
            begin
                case ($urandom_range(0, 7))
                    0:       b = 8'h00;
                    1:       b = 8'hff;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                dq.push_back(b);
            end
            send_stream(dq);
        end
        push <= 1'b0;

        while (sb.expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.expected_chars.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
